// ----- design/assert_macros.svh -----
// Assertion macros for the RTL files, included by the accumulator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, off while reset is held
`define SPALF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define SPALF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `SPALF_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define SPALF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `SPALF_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ----- design/spalf_pkg.sv -----
// Shared types and constants of the scan pixel averager
`default_nettype none

package spalf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SPP_W      = 8;
  localparam int SIZE_W     = 13;
  localparam int IDX_W      = 12;
  localparam int SUM_W      = 24;
  localparam int QUOT_W     = 16;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET      = 16'd8192;
  localparam logic [SIZE_W-1:0]   MAX_PIXELS_PER_LINE = 13'd4096;
  localparam logic [SIZE_W-1:0]   MAX_LINES           = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_PIXEL = 2'd0,
    REG_LINES_PER_FRAME   = 2'd1,
    REG_PIXELS_PER_LINE   = 2'd2,
    REG_FLIP_PHASE        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SPP_W-1:0]  samples_per_pixel;
    logic [SIZE_W-1:0] lines_per_frame;
    logic [SIZE_W-1:0] pixels_per_line;
    logic              flip_phase;
  } cfg_t;

  // One pixel on its way through the divider chain
  typedef struct packed {
    logic [SPP_W-1:0]  rem;
    logic [QUOT_W-1:0] qd;
    logic [SPP_W-1:0]  divisor;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              empty;
    logic              frame_end;
  } div_word_t;

endpackage

`default_nettype wire

// ----- design/spalf_accum.sv -----
// Sample accumulator and scan position counters feeding the divider chain
`default_nettype none

`include "assert_macros.svh"

module spalf_accum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire spalf_pkg::cfg_t               cfg,
  input  wire logic                          in_valid,
  input  wire logic [spalf_pkg::SAMPLE_W-1:0] in_raw_sample,
  output logic                               in_stall,
  input  wire logic                          down_hold,
  output logic                               word_valid,
  output spalf_pkg::div_word_t               word
);

  logic [spalf_pkg::SPP_W-1:0]  sample_index_r, sample_index_nxt;
  logic [spalf_pkg::SUM_W-1:0]  kept_sum_r, kept_sum_nxt;
  logic [spalf_pkg::SPP_W-1:0]  kept_count_r, kept_count_nxt;
  logic [spalf_pkg::IDX_W-1:0]  column_index_r, column_index_nxt;
  logic [spalf_pkg::IDX_W-1:0]  row_index_r, row_index_nxt;

  logic                         accept;
  logic                         keep;
  logic [spalf_pkg::SAMPLE_W-1:0] corr;
  logic [spalf_pkg::SUM_W-1:0]  sum_new;
  logic [spalf_pkg::SPP_W-1:0]  cnt_new;
  logic [spalf_pkg::SPP_W-1:0]  idx_new;
  logic [spalf_pkg::SPP_W-1:0]  spp;
  logic [spalf_pkg::SIZE_W-1:0] ppl, lpf;
  logic [spalf_pkg::SIZE_W-1:0] col_w, row_w, col_inc, row_inc, col_mir;
  logic                         finish, last_col, last_row, mirror;

  assign accept   = in_valid && !down_hold;
  assign in_stall = down_hold;

  always_comb begin
    spp = (cfg.samples_per_pixel == '0) ? spalf_pkg::SPP_W'(1) : cfg.samples_per_pixel;

    if (cfg.pixels_per_line == '0) begin
      ppl = spalf_pkg::SIZE_W'(1);
    end else if (cfg.pixels_per_line > spalf_pkg::MAX_PIXELS_PER_LINE) begin
      ppl = spalf_pkg::MAX_PIXELS_PER_LINE;
    end else begin
      ppl = cfg.pixels_per_line;
    end

    if (cfg.lines_per_frame == '0) begin
      lpf = spalf_pkg::SIZE_W'(1);
    end else if (cfg.lines_per_frame > spalf_pkg::MAX_LINES) begin
      lpf = spalf_pkg::MAX_LINES;
    end else begin
      lpf = cfg.lines_per_frame;
    end

    keep    = (in_raw_sample >= spalf_pkg::SAMPLE_OFFSET);
    corr    = in_raw_sample - spalf_pkg::SAMPLE_OFFSET;
    sum_new = keep ? kept_sum_r + spalf_pkg::SUM_W'(corr) : kept_sum_r;
    cnt_new = keep ? kept_count_r + spalf_pkg::SPP_W'(1) : kept_count_r;
    idx_new = sample_index_r + spalf_pkg::SPP_W'(1);
    finish  = (idx_new == '0) || (idx_new >= spp);

    // Counters beyond the current size act as the last position
    col_w = ({1'b0, column_index_r} < ppl) ? {1'b0, column_index_r} : ppl - 13'd1;
    row_w = ({1'b0, row_index_r} < lpf) ? {1'b0, row_index_r} : lpf - 13'd1;
    col_inc  = col_w + 13'd1;
    row_inc  = row_w + 13'd1;
    last_col = (col_inc >= ppl);
    last_row = (row_inc >= lpf);
    mirror   = (row_w[0] == cfg.flip_phase);
    col_mir  = ppl - 13'd1 - col_w;

    word.rem       = sum_new[spalf_pkg::SUM_W-1:spalf_pkg::QUOT_W];
    word.qd        = sum_new[spalf_pkg::QUOT_W-1:0];
    word.divisor   = cnt_new;
    word.row       = row_w[spalf_pkg::IDX_W-1:0];
    word.col       = mirror ? col_mir[spalf_pkg::IDX_W-1:0] : col_w[spalf_pkg::IDX_W-1:0];
    word.empty     = (cnt_new == '0);
    word.frame_end = last_col && last_row;
    word_valid     = accept && finish;

    sample_index_nxt = sample_index_r;
    kept_sum_nxt     = kept_sum_r;
    kept_count_nxt   = kept_count_r;
    column_index_nxt = column_index_r;
    row_index_nxt    = row_index_r;
    if (accept) begin
      if (finish) begin
        sample_index_nxt = '0;
        kept_sum_nxt     = '0;
        kept_count_nxt   = '0;
        if (last_col) begin
          column_index_nxt = '0;
          row_index_nxt    = last_row ? '0 : row_inc[spalf_pkg::IDX_W-1:0];
        end else begin
          column_index_nxt = col_inc[spalf_pkg::IDX_W-1:0];
        end
      end else begin
        sample_index_nxt = idx_new;
        kept_sum_nxt     = sum_new;
        kept_count_nxt   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      kept_sum_r     <= '0;
      kept_count_r   <= '0;
      column_index_r <= '0;
      row_index_r    <= '0;
    end else begin
      sample_index_r <= sample_index_nxt;
      kept_sum_r     <= kept_sum_nxt;
      kept_count_r   <= kept_count_nxt;
      column_index_r <= column_index_nxt;
      row_index_r    <= row_index_nxt;
    end
  end

  `SPALF_ASSERT(a_count_le_index, clk, rst_n, kept_count_r <= sample_index_r, "kept count above sample index")
  `SPALF_ASSERT_NXT(a_pixel_clears, clk, rst_n, word_valid, (sample_index_r == '0) && (kept_sum_r == '0), "accumulator not cleared after pixel")
  `SPALF_ASSERT_NXT(a_frame_wraps, clk, rst_n, word_valid && word.frame_end, (row_index_r == '0) && (column_index_r == '0), "position did not wrap at frame end")

endmodule

`default_nettype wire

// ----- design/spalf_div_cell.sv -----
// One restoring-division step with its pipeline register
`default_nettype none

module spalf_div_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 up_valid,
  input  wire spalf_pkg::div_word_t up_word,
  output logic                      hold_up,
  input  wire logic                 down_hold,
  output logic                      dn_valid,
  output spalf_pkg::div_word_t      dn_word
);

  logic                      v_r;
  spalf_pkg::div_word_t      w_r;
  spalf_pkg::div_word_t      step;
  logic [spalf_pkg::SPP_W:0] trial;
  logic [spalf_pkg::SPP_W:0] diff;
  logic                      ge;

  // Shift the next dividend bit into the remainder, subtract if it fits
  always_comb begin
    trial   = {up_word.rem, up_word.qd[spalf_pkg::QUOT_W-1]};
    diff    = trial - {1'b0, up_word.divisor};
    ge      = (trial >= {1'b0, up_word.divisor});
    step    = up_word;
    step.rem = ge ? diff[spalf_pkg::SPP_W-1:0] : trial[spalf_pkg::SPP_W-1:0];
    step.qd  = {up_word.qd[spalf_pkg::QUOT_W-2:0], ge};
  end

  assign hold_up  = v_r && down_hold;
  assign dn_valid = v_r;
  assign dn_word  = w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!hold_up) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold_up && up_valid) begin
      w_r <= step;
    end
  end

endmodule

`default_nettype wire

// ----- design/scan_pixel_average_line_flip.sv -----
// Top level: configuration registers, accumulator and divider cell chain
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_raw_sample
//  out_    | output    | out_valid/out_stall| row, column, value, empty flag, frame end
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One raw sample is taken per cycle while in_stall is low; a sample that finishes a
// pixel enters a chain of 16 division cells, one quotient bit per cell. Reset clears
// the counters, the accumulator, all cell valid bits and the registers to their
// defaults. A held output stalls the chain cell by cell; empty cells keep filling,
// and input stalls only once the first cell is held.
`default_nettype none

module scan_pixel_average_line_flip (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [spalf_pkg::SAMPLE_W-1:0]     in_raw_sample,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [spalf_pkg::IDX_W-1:0]             out_pixel_row,
  output logic [spalf_pkg::IDX_W-1:0]             out_pixel_column,
  output logic [spalf_pkg::QUOT_W-1:0]            out_pixel_value,
  output logic                                    out_no_valid_samples,
  output logic                                    out_frame_end,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [spalf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [spalf_pkg::SIZE_W-1:0]       cfg_data
);

  spalf_pkg::cfg_t      cfg_r;
  spalf_pkg::div_word_t stage_w [spalf_pkg::DIV_STEPS+1];
  logic                 stage_v [spalf_pkg::DIV_STEPS+1];
  logic                 hold    [spalf_pkg::DIV_STEPS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.samples_per_pixel <= spalf_pkg::SPP_W'(1);
      cfg_r.lines_per_frame   <= spalf_pkg::SIZE_W'(512);
      cfg_r.pixels_per_line   <= spalf_pkg::SIZE_W'(512);
      cfg_r.flip_phase        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spalf_pkg::REG_SAMPLES_PER_PIXEL: begin
          cfg_r.samples_per_pixel <= cfg_data[spalf_pkg::SPP_W-1:0];
        end
        spalf_pkg::REG_LINES_PER_FRAME: begin
          cfg_r.lines_per_frame <= cfg_data;
        end
        spalf_pkg::REG_PIXELS_PER_LINE: begin
          cfg_r.pixels_per_line <= cfg_data;
        end
        spalf_pkg::REG_FLIP_PHASE: begin
          cfg_r.flip_phase <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  spalf_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_raw_sample (in_raw_sample),
    .in_stall      (in_stall),
    .down_hold     (hold[0]),
    .word_valid    (stage_v[0]),
    .word          (stage_w[0])
  );

  for (genvar i = 0; i < spalf_pkg::DIV_STEPS; i++) begin : g_cell
    spalf_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (stage_v[i]),
      .up_word   (stage_w[i]),
      .hold_up   (hold[i]),
      .down_hold (hold[i+1]),
      .dn_valid  (stage_v[i+1]),
      .dn_word   (stage_w[i+1])
    );
  end

  assign hold[spalf_pkg::DIV_STEPS] = out_stall;

  // Last cell register is the output register; an empty pixel reads as zero
  assign out_valid            = stage_v[spalf_pkg::DIV_STEPS];
  assign out_pixel_row        = stage_w[spalf_pkg::DIV_STEPS].row;
  assign out_pixel_column     = stage_w[spalf_pkg::DIV_STEPS].col;
  assign out_no_valid_samples = stage_w[spalf_pkg::DIV_STEPS].empty;
  assign out_frame_end        = stage_w[spalf_pkg::DIV_STEPS].frame_end;
  assign out_pixel_value      = stage_w[spalf_pkg::DIV_STEPS].empty ? '0
                                : stage_w[spalf_pkg::DIV_STEPS].qd;

endmodule

`default_nettype wire
